[hw/rtl/mie_pkg.sv]
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants of the MIPS32 integer execute block
// Instruction codes, memory geometry and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  localparam int DMEM_BYTES = 4096;
  localparam int DMEM_ROWS  = DMEM_BYTES / 4;
  localparam int ROW_W      = $clog2(DMEM_ROWS);
  localparam int ADDR_W     = $clog2(DMEM_BYTES);

  localparam int IN_W  = 80;
  localparam int OUT_W = 208;

  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
  localparam logic [31:0] SYSCALL_EXIT   = 32'h0000_000A;
  localparam logic [4:0]  REG_V0         = 5'd2;
  localparam logic [4:0]  REG_RA         = 5'd31;

  // opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ   = 5'd0;
  localparam logic [4:0] RI_BGEZ   = 5'd1;
  localparam logic [4:0] RI_BLTZAL = 5'd16;
  localparam logic [4:0] RI_BGEZAL = 5'd17;

  typedef enum logic [1:0] {
    K_SIMPLE,
    K_LOAD,
    K_DIV
  } kind_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_fin;
    logic div_step;
    logic div_fin;
    logic ret_load;
    logic clr_step;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_last;
    logic  clr_last;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/mie_ctrl.sv]
// ----------------------------------------------------------------------------
// mie_ctrl: sequencing state machine
// Runs the post-reset clear, then steps one item through execute, load, divide and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mie_ctrl
  import mie_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DIV,
    S_DFIN,
    S_RET
  } state_t;

  state_t state_r;
  logic   out_vld_r;

  assign out_tvalid = out_vld_r;
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.accept = in_tvalid && in_tready;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_EXEC:  cmd.exec     = 1'b1;
      S_LOAD:  cmd.load_fin = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_DFIN:  cmd.div_fin  = 1'b1;
      S_RET:   cmd.ret_load = !out_vld_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.ret_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: if (sts.clr_last) state_r <= S_IDLE;
        S_IDLE:  if (cmd.accept) state_r <= S_EXEC;
        S_EXEC: begin
          unique case (sts.kind)
            K_LOAD:  state_r <= S_LOAD;
            K_DIV:   state_r <= S_DIV;
            default: state_r <= S_RET;
          endcase
        end
        S_LOAD:  state_r <= S_RET;
        S_DIV:   if (sts.div_last) state_r <= S_DFIN;
        S_DFIN:  state_r <= S_RET;
        S_RET:   if (cmd.ret_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mie_datapath.sv]
// ----------------------------------------------------------------------------
// mie_datapath: architectural state and execute logic
// Register file, HI/LO, PC, banked byte memory, multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mie_datapath
  import mie_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  output dp_sts_t          sts,
  input  logic [IN_W-1:0]  in_data,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  output logic [OUT_W-1:0] out_data
);

  // input beat fields
  logic        in_cmd;
  logic [31:0] in_instr;
  logic [4:0]  rd_a, rd_b;

  assign in_cmd   = in_data[0];
  assign in_instr = in_data[32:1];
  assign rd_a     = in_instr[25:21];
  // syscall tests $v0, so port B looks there instead of rt
  assign rd_b = (in_instr[31:26] == OP_SPECIAL && in_instr[5:0] == FN_SYSCALL) ?
                REG_V0 : in_instr[20:16];

  // latched item
  logic              cmd_r;
  logic [31:0]       instr_r;
  logic [ADDR_W-1:0] pa_r;
  logic [31:0]       pd_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_cmd;
      instr_r <= in_instr;
      pa_r    <= ADDR_W'(in_data[44:33]);
      pd_r    <= in_data[76:45];
    end
  end

  // architectural state
  logic [31:0] pc_r, hi_r, lo_r;
  logic        halt_r;
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] a_q_r, b_q_r;
  logic        a_v_r, b_v_r;
  logic [31:0] a, b;

  assign a = a_v_r ? a_q_r : '0;
  assign b = b_v_r ? b_q_r : '0;

  // decode
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, pc4, btarget, add_ab, sub_ab, ea;

  assign op      = instr_r[31:26];
  assign rt      = instr_r[20:16];
  assign rd      = instr_r[15:11];
  assign sh      = instr_r[10:6];
  assign fn      = instr_r[5:0];
  assign imm     = instr_r[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign pc4     = pc_r + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign add_ab  = a + b;
  assign sub_ab  = a - b;
  assign ea      = a + simm;

  logic               mul_sgn;
  logic signed [65:0] prod;
  assign mul_sgn = (fn == FN_MULT);
  assign prod    = $signed({mul_sgn & a[31], a}) * $signed({mul_sgn & b[31], b});

  logic [31:0] x_npc, x_val, x_mval, x_hi, x_lo;
  logic [4:0]  x_idx;
  logic [2:0]  x_nb;
  logic        x_wr, x_ovf, x_dz, x_mw, x_halt, x_hi_we, x_lo_we, x_load, x_div;

  always_comb begin
    x_npc   = pc4;
    x_wr    = 1'b0;
    x_idx   = rd;
    x_val   = '0;
    x_ovf   = 1'b0;
    x_dz    = 1'b0;
    x_mw    = 1'b0;
    x_mval  = '0;
    x_nb    = 3'd0;
    x_halt  = 1'b0;
    x_hi_we = 1'b0;
    x_lo_we = 1'b0;
    x_hi    = a;
    x_lo    = a;
    x_load  = 1'b0;
    x_div   = 1'b0;
    unique case (op)
      OP_SPECIAL: begin
        unique case (fn)
          FN_SLL:  begin x_wr = 1'b1; x_val = b << sh; end
          FN_SRL:  begin x_wr = 1'b1; x_val = b >> sh; end
          FN_SRA:  begin x_wr = 1'b1; x_val = 32'($signed(b) >>> sh); end
          FN_SLLV: begin x_wr = 1'b1; x_val = b << a[4:0]; end
          FN_SRLV: begin x_wr = 1'b1; x_val = b >> a[4:0]; end
          FN_SRAV: begin x_wr = 1'b1; x_val = 32'($signed(b) >>> a[4:0]); end
          FN_JR:   x_npc = a;
          FN_JALR: begin x_npc = a; x_wr = 1'b1; x_val = pc4; end
          FN_SYSCALL: x_halt = (b == SYSCALL_EXIT);
          FN_MFHI: begin x_wr = 1'b1; x_val = hi_r; end
          FN_MTHI: x_hi_we = 1'b1;
          FN_MFLO: begin x_wr = 1'b1; x_val = lo_r; end
          FN_MTLO: x_lo_we = 1'b1;
          FN_MULT, FN_MULTU: begin
            x_hi_we = 1'b1;
            x_lo_we = 1'b1;
            x_hi    = prod[63:32];
            x_lo    = prod[31:0];
          end
          FN_DIV, FN_DIVU: begin
            x_dz  = (b == '0);
            x_div = (b != '0);
          end
          FN_ADD: begin
            x_wr  = 1'b1;
            x_val = add_ab;
            x_ovf = (a[31] ^ add_ab[31]) & (b[31] ^ add_ab[31]);
          end
          FN_ADDU: begin x_wr = 1'b1; x_val = add_ab; end
          FN_SUB: begin
            x_wr  = 1'b1;
            x_val = sub_ab;
            x_ovf = (a[31] ^ b[31]) & (a[31] ^ sub_ab[31]);
          end
          FN_SUBU: begin x_wr = 1'b1; x_val = sub_ab; end
          FN_AND:  begin x_wr = 1'b1; x_val = a & b; end
          FN_OR:   begin x_wr = 1'b1; x_val = a | b; end
          FN_XOR:  begin x_wr = 1'b1; x_val = a ^ b; end
          FN_NOR:  begin x_wr = 1'b1; x_val = ~(a | b); end
          FN_SLT:  begin x_wr = 1'b1; x_val = {31'd0, $signed(a) < $signed(b)}; end
          FN_SLTU: begin x_wr = 1'b1; x_val = {31'd0, a < b}; end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        x_idx = REG_RA;
        x_val = pc4;
        unique case (rt)
          RI_BLTZ:   if (a[31]) x_npc = btarget;
          RI_BGEZ:   if (!a[31]) x_npc = btarget;
          RI_BLTZAL: begin x_wr = 1'b1; if (a[31]) x_npc = btarget; end
          RI_BGEZAL: begin x_wr = 1'b1; if (!a[31]) x_npc = btarget; end
          default: ;
        endcase
      end
      OP_J:    x_npc = {pc4[31:28], instr_r[25:0], 2'b00};
      OP_JAL: begin
        x_npc = {pc4[31:28], instr_r[25:0], 2'b00};
        x_wr  = 1'b1;
        x_idx = REG_RA;
        x_val = pc4;
      end
      OP_BEQ:  if (a == b) x_npc = btarget;
      OP_BNE:  if (a != b) x_npc = btarget;
      OP_BLEZ: if (a == '0 || a[31]) x_npc = btarget;
      OP_BGTZ: if (a != '0 && !a[31]) x_npc = btarget;
      OP_ADDI: begin
        x_wr  = 1'b1;
        x_idx = rt;
        x_val = ea;
        x_ovf = (a[31] ^ ea[31]) & (simm[31] ^ ea[31]);
      end
      OP_ADDIU: begin x_wr = 1'b1; x_idx = rt; x_val = ea; end
      OP_SLTI: begin
        x_wr  = 1'b1;
        x_idx = rt;
        x_val = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin x_wr = 1'b1; x_idx = rt; x_val = {31'd0, a < simm}; end
      OP_ANDI:  begin x_wr = 1'b1; x_idx = rt; x_val = a & {16'd0, imm}; end
      OP_ORI:   begin x_wr = 1'b1; x_idx = rt; x_val = a | {16'd0, imm}; end
      OP_XORI:  begin x_wr = 1'b1; x_idx = rt; x_val = a ^ {16'd0, imm}; end
      OP_LUI:   begin x_wr = 1'b1; x_idx = rt; x_val = {imm, 16'd0}; end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        x_wr   = 1'b1;
        x_idx  = rt;
        x_load = 1'b1;
      end
      OP_SB: begin x_mw = 1'b1; x_nb = 3'd1; x_mval = {24'd0, b[7:0]}; end
      OP_SH: begin x_mw = 1'b1; x_nb = 3'd2; x_mval = {16'd0, b[15:0]}; end
      OP_SW: begin x_mw = 1'b1; x_nb = 3'd4; x_mval = b; end
      default: ;
    endcase
  end

  logic eff, wr_ok;
  assign eff   = cmd.exec && !cmd_r && !halt_r;
  assign wr_ok = x_wr && (x_idx != '0);

  // ---------------------------------------------------------------- memory
  logic [ADDR_W-1:0] acc_addr;
  logic [1:0]        acc_lo, ld_lo_r;
  logic [ROW_W-1:0]  acc_row, clr_r;
  logic [31:0]       mem_wdat;
  logic [2:0]        mem_nb;
  logic              mem_we;
  logic [7:0]        bank_q [4];

  assign acc_addr = cmd_r ? pa_r : ea[ADDR_W-1:0];
  assign acc_lo   = acc_addr[1:0];
  assign acc_row  = acc_addr[ADDR_W-1:2];
  assign mem_wdat = cmd_r ? pd_r : x_mval;
  assign mem_nb   = cmd_r ? 3'd4 : x_nb;
  assign mem_we   = cmd.exec && (cmd_r || (!halt_r && x_mw));

  // byte k of an access lands in bank (lo+k)%4, one row further on wrap
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]       mem [DMEM_ROWS];
    logic [1:0]       k;
    logic [ROW_W-1:0] row;

    assign k   = 2'(j) - acc_lo;
    assign row = acc_row + ROW_W'(2'(j) < acc_lo);

    always_ff @(posedge clk) begin
      if (cmd.clr_step) begin
        mem[clr_r] <= '0;
      end else if (mem_we && ({1'b0, k} < mem_nb)) begin
        mem[row] <= 8'(mem_wdat >> {k, 3'b000});
      end
      if (cmd.exec) begin
        bank_q[j] <= mem[row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ld_lo_r <= acc_lo;
    end
  end

  logic [31:0] ld_word, ld_val;
  assign ld_word = {bank_q[ld_lo_r + 2'd3], bank_q[ld_lo_r + 2'd2],
                    bank_q[ld_lo_r + 2'd1], bank_q[ld_lo_r]};

  always_comb begin
    unique case (op)
      OP_LB:   ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
      OP_LH:   ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
      OP_LBU:  ld_val = {24'd0, ld_word[7:0]};
      OP_LHU:  ld_val = {16'd0, ld_word[15:0]};
      default: ld_val = ld_word;
    endcase
  end

  // --------------------------------------------------------- register file
  logic        rf_we;
  logic [4:0]  rf_widx;
  logic [31:0] rf_wval;

  always_comb begin
    rf_we   = 1'b0;
    rf_widx = rt;
    rf_wval = ld_val;
    if (cmd.load_fin) begin
      rf_we = (rt != '0);
    end else if (eff && wr_ok && !x_load) begin
      rf_we   = 1'b1;
      rf_widx = x_idx;
      rf_wval = x_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rf_widx] <= rf_wval;
    end
    if (cmd.accept) begin
      a_q_r <= rf_mem[rd_a];
      b_q_r <= rf_mem[rd_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_r[rf_widx] <= 1'b1;
      end
      if (cmd.accept) begin
        a_v_r <= rf_vld_r[rd_a];
        b_v_r <= rf_vld_r[rd_b];
      end
    end
  end

  // --------------------------------------------------------------- divider
  logic [31:0] q_r, r_r, d_r;
  logic [4:0]  cnt_r;
  logic        nq_r, nr_r, div_sgn, na, nb;
  logic [32:0] trial;

  assign div_sgn = (fn == FN_DIV);
  assign na      = div_sgn & a[31];
  assign nb      = div_sgn & b[31];
  assign trial   = {r_r, q_r[31]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (eff && x_div) begin
      q_r   <= na ? -a : a;
      d_r   <= nb ? -b : b;
      r_r   <= '0;
      nq_r  <= na ^ nb;
      nr_r  <= na;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!trial[32]) begin
        r_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= {r_r[30:0], q_r[31]};
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------- PC, HI/LO, halt
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= START_PC_RESET;
      hi_r   <= '0;
      lo_r   <= '0;
      halt_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end else if (eff) begin
        pc_r <= x_npc;
      end
      if (eff && x_halt) begin
        halt_r <= 1'b1;
      end
      if (cmd.div_fin) begin
        hi_r <= nr_r ? -r_r : r_r;
        lo_r <= nq_r ? -q_r : q_r;
      end else if (eff) begin
        if (x_hi_we) hi_r <= x_hi;
        if (x_lo_we) lo_r <= x_lo;
      end
    end
  end

  // ----------------------------------------------------- result fields
  logic        res_wr_r, res_ovf_r, res_dz_r, res_mw_r;
  logic [4:0]  res_idx_r;
  logic [31:0] res_val_r, res_maddr_r, res_mval_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_wr_r    <= eff && wr_ok && !x_load;
      res_idx_r   <= (eff && wr_ok && !x_load) ? x_idx : '0;
      res_val_r   <= (eff && wr_ok && !x_load) ? x_val : '0;
      res_ovf_r   <= eff && x_ovf;
      res_dz_r    <= eff && x_dz;
      res_mw_r    <= eff && x_mw;
      res_maddr_r <= (eff && x_mw) ? ea : '0;
      res_mval_r  <= (eff && x_mw) ? x_mval : '0;
    end else if (cmd.load_fin && (rt != '0)) begin
      res_wr_r  <= 1'b1;
      res_idx_r <= rt;
      res_val_r <= ld_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ret_load) begin
      out_data <= {6'd0, res_mval_r, res_maddr_r, res_mw_r, res_dz_r, res_ovf_r,
                   lo_r, hi_r, res_val_r, res_idx_r, res_wr_r, halt_r, pc_r};
    end
  end

  // ---------------------------------------------------------------- status
  always_comb begin
    sts.div_last = (cnt_r == 5'd31);
    sts.clr_last = (clr_r == ROW_W'(DMEM_ROWS - 1));
    if (cmd_r || halt_r) begin
      sts.kind = K_SIMPLE;
    end else if (x_load) begin
      sts.kind = K_LOAD;
    end else if (x_div) begin
      sts.kind = K_DIV;
    end else begin
      sts.kind = K_SIMPLE;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mips32_integer_execute.sv]
// ----------------------------------------------------------------------------
// mips32_integer_execute: MIPS32 integer execute block
// One instruction word or one memory preload per input beat, one result beat.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  in_*     | in        | cmd, instr, preload_address, preload_data
//  out_*    | out       | next_pc, flags, register write, HI/LO, store
//  cfg_*    | in        | start_pc (also loads the PC)
//
// Simple instructions and preloads pass accept, execute and hand-off; loads
// add a registered bank read, div/divu the 32-step radix-2 divider.
// After reset a clearing pass over DMEM_BYTES/4 = 1024 rows zeroes the data
// memory; in_tready stays low meanwhile. A new beat is accepted while the
// previous result still waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mips32_integer_execute
  import mie_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [0] cmd, [32:1] instr, [44:33] preload_address, [76:45] preload_data
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [31:0] next_pc, [32] halted, [33] reg_written, [38:34] reg_index,
  // [70:39] reg_value, [102:71] hi_value, [134:103] lo_value, [135] overflow,
  // [136] divide_by_zero, [137] mem_written, [169:138] mem_address,
  // [201:170] mem_value
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  mie_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mie_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_tdata)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat accepted while item in flight");

  a_no_reg_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[33] |-> out_tdata[70:34] == '0)
    else $error("register fields not cleared without a write");

  a_store_no_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[137] |-> !out_tdata[33])
    else $error("store reported with a register write");

  a_zero_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[38:34] != '0)
    else $error("write to register zero reported");
`endif

endmodule

`default_nettype wire

[tb/mips32_integer_execute_test.sv]
// ----------------------------------------------------------------------------
// mips32_integer_execute_test: self-checking bench of the MIPS32 execute block
// Drives preloads and instruction words on the input stream, predicts every
// result beat with a behavioral model of the machine state and compares the
// output stream field by field, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips32_integer_execute_test;
  import mie_pkg::*;

  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;
  localparam int   CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [31:0] mem_value;
    logic [31:0] mem_address;
    logic        mem_written;
    logic        divide_by_zero;
    logic        overflow;
    logic [31:0] lo_value;
    logic [31:0] hi_value;
    logic [31:0] reg_value;
    logic [4:0]  reg_index;
    logic        reg_written;
    logic        halted;
    logic [31:0] next_pc;
  } retire_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  mips32_integer_execute dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // machine state mirror
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q;
  logic        halt_q;
  logic [7:0]  dmem [DMEM_BYTES];

  retire_t pending_retires[$];
  int errors = 0;
  int cycles = 0;
  bit stall_enable = 1'b1;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] mem_rd(input logic [31:0] addr, input int nb);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < nb; k++) v[8*k +: 8] = dmem[(addr + k) % DMEM_BYTES];
    return v;
  endfunction

  task automatic mem_wr(input logic [31:0] addr, input logic [31:0] v, input int nb);
    for (int k = 0; k < nb; k++) dmem[(addr + k) % DMEM_BYTES] = v[8*k +: 8];
  endtask

  task automatic model_reset();
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    hi_q = '0; lo_q = '0; pc_q = START_PC_RESET; halt_q = 1'b0;
  endtask

  task automatic predict_retire(input logic cmd, input logic [31:0] ins,
                                input logic [11:0] paddr, input logic [31:0] pdata);
    retire_t r;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, ea, bt, npc, res, q, m, ma, mb;
    logic [63:0] prod;
    r = '0;
    if (cmd == CMD_PRELOAD) mem_wr({20'd0, paddr}, pdata, 4);
    else if (!halt_q) begin
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
      sh = ins[10:6]; fn = ins[5:0];
      imm = {16'd0, ins[15:0]};
      simm = {{16{ins[15]}}, ins[15:0]};
      a = gpr[rs]; b = gpr[rt];
      ea = a + simm;
      bt = pc_q + 32'd4 + (simm << 2);
      npc = pc_q + 32'd4;
      if (op == OP_SPECIAL) begin
        r.reg_index = rd;
        case (fn)
          FN_SLL:  begin r.reg_written = 1; r.reg_value = b << sh; end
          FN_SRL:  begin r.reg_written = 1; r.reg_value = b >> sh; end
          FN_SRA:  begin r.reg_written = 1; r.reg_value = $signed(b) >>> sh; end
          FN_SLLV: begin r.reg_written = 1; r.reg_value = b << a[4:0]; end
          FN_SRLV: begin r.reg_written = 1; r.reg_value = b >> a[4:0]; end
          FN_SRAV: begin r.reg_written = 1; r.reg_value = $signed(b) >>> a[4:0]; end
          FN_JR:   npc = a;
          FN_JALR: begin npc = a; r.reg_written = 1; r.reg_value = pc_q + 32'd4; end
          FN_SYSCALL: if (gpr[REG_V0] == SYSCALL_EXIT) halt_q = 1'b1;
          FN_MFHI: begin r.reg_written = 1; r.reg_value = hi_q; end
          FN_MTHI: hi_q = a;
          FN_MFLO: begin r.reg_written = 1; r.reg_value = lo_q; end
          FN_MTLO: lo_q = a;
          FN_MULT: begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            hi_q = prod[63:32]; lo_q = prod[31:0];
          end
          FN_MULTU: begin
            prod = {32'd0, a} * {32'd0, b};
            hi_q = prod[63:32]; lo_q = prod[31:0];
          end
          FN_DIV: begin
            if (b == 0) r.divide_by_zero = 1;
            else begin
              ma = a[31] ? -a : a; mb = b[31] ? -b : b;
              q = ma / mb; m = ma % mb;
              lo_q = (a[31] != b[31]) ? -q : q;
              hi_q = a[31] ? -m : m;
            end
          end
          FN_DIVU: begin
            if (b == 0) r.divide_by_zero = 1;
            else begin lo_q = a / b; hi_q = a % b; end
          end
          FN_ADD: begin
            res = a + b; r.overflow = (a[31] ~^ b[31]) && (res[31] != a[31]);
            r.reg_written = 1; r.reg_value = res;
          end
          FN_ADDU: begin r.reg_written = 1; r.reg_value = a + b; end
          FN_SUB: begin
            res = a - b; r.overflow = (a[31] != b[31]) && (res[31] != a[31]);
            r.reg_written = 1; r.reg_value = res;
          end
          FN_SUBU: begin r.reg_written = 1; r.reg_value = a - b; end
          FN_AND:  begin r.reg_written = 1; r.reg_value = a & b; end
          FN_OR:   begin r.reg_written = 1; r.reg_value = a | b; end
          FN_XOR:  begin r.reg_written = 1; r.reg_value = a ^ b; end
          FN_NOR:  begin r.reg_written = 1; r.reg_value = ~(a | b); end
          FN_SLT:  begin r.reg_written = 1; r.reg_value = {31'd0, $signed(a) < $signed(b)}; end
          FN_SLTU: begin r.reg_written = 1; r.reg_value = {31'd0, a < b}; end
          default: ;
        endcase
      end else if (op == OP_REGIMM) begin
        case (rt)
          RI_BLTZ: if (a[31]) npc = bt;
          RI_BGEZ: if (!a[31]) npc = bt;
          RI_BLTZAL, RI_BGEZAL: begin
            if (a[31] == (rt == RI_BLTZAL)) npc = bt;
            r.reg_written = 1; r.reg_index = REG_RA; r.reg_value = pc_q + 32'd4;
          end
          default: ;
        endcase
      end else begin
        r.reg_index = rt;
        case (op)
          OP_J, OP_JAL: begin
            npc = {npc[31:28], ins[25:0], 2'b00};
            if (op == OP_JAL) begin
              r.reg_written = 1; r.reg_index = REG_RA; r.reg_value = pc_q + 32'd4;
            end
          end
          OP_BEQ:  if (a == b) npc = bt;
          OP_BNE:  if (a != b) npc = bt;
          OP_BLEZ: if (a == 0 || a[31]) npc = bt;
          OP_BGTZ: if (a != 0 && !a[31]) npc = bt;
          OP_ADDI: begin
            res = a + simm; r.overflow = (a[31] ~^ simm[31]) && (res[31] != a[31]);
            r.reg_written = 1; r.reg_value = res;
          end
          OP_ADDIU: begin r.reg_written = 1; r.reg_value = a + simm; end
          OP_SLTI:  begin r.reg_written = 1; r.reg_value = {31'd0, $signed(a) < $signed(simm)}; end
          OP_SLTIU: begin r.reg_written = 1; r.reg_value = {31'd0, a < simm}; end
          OP_ANDI:  begin r.reg_written = 1; r.reg_value = a & imm; end
          OP_ORI:   begin r.reg_written = 1; r.reg_value = a | imm; end
          OP_XORI:  begin r.reg_written = 1; r.reg_value = a ^ imm; end
          OP_LUI:   begin r.reg_written = 1; r.reg_value = imm << 16; end
          OP_LB: begin
            res = mem_rd(ea, 1); r.reg_written = 1; r.reg_value = {{24{res[7]}}, res[7:0]};
          end
          OP_LH: begin
            res = mem_rd(ea, 2); r.reg_written = 1; r.reg_value = {{16{res[15]}}, res[15:0]};
          end
          OP_LW:  begin r.reg_written = 1; r.reg_value = mem_rd(ea, 4); end
          OP_LBU: begin r.reg_written = 1; r.reg_value = mem_rd(ea, 1); end
          OP_LHU: begin r.reg_written = 1; r.reg_value = mem_rd(ea, 2); end
          OP_SB: begin
            r.mem_written = 1; r.mem_address = ea; r.mem_value = b & 32'hFF; mem_wr(ea, b, 1);
          end
          OP_SH: begin
            r.mem_written = 1; r.mem_address = ea; r.mem_value = b & 32'hFFFF;
            mem_wr(ea, b, 2);
          end
          OP_SW: begin
            r.mem_written = 1; r.mem_address = ea; r.mem_value = b; mem_wr(ea, b, 4);
          end
          default: ;
        endcase
      end
      if (r.reg_written && r.reg_index != 0) gpr[r.reg_index] = r.reg_value;
      else begin r.reg_written = 0; r.reg_index = 0; r.reg_value = 0; end
      pc_q = npc;
    end
    r.next_pc = pc_q; r.halted = halt_q; r.hi_value = hi_q; r.lo_value = lo_q;
    pending_retires.push_back(r);
  endtask

  task automatic random_gap();
    int n;
    if (!stall_enable) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  // one input beat; prediction made at acceptance
  task automatic send_beat(input logic cmd, input logic [31:0] ins,
                           input logic [11:0] paddr = '0, input logic [31:0] pdata = '0);
    random_gap();
    // the previous beat drops tvalid on the negedge it ends on
    @(negedge clk);
    in_tdata <= {3'd0, pdata, paddr, ins, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_retire(cmd, ins, paddr, pdata);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic exec(input logic [31:0] ins);
    send_beat(CMD_EXEC, ins);
  endtask

  function automatic logic [31:0] r_type(input logic [4:0] rs, rt, rd, sh,
                                         input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs, rt,
                                         input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // load a full 32-bit constant with lui/ori
  task automatic set_reg(input logic [4:0] idx, input logic [31:0] v);
    exec(i_type(OP_LUI, 5'd0, idx, v[31:16]));
    exec(i_type(OP_ORI, idx, idx, v[15:0]));
  endtask

  task automatic drain();
    while (pending_retires.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_start_pc(input logic [31:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    pc_q = v;
  endtask

  // result stream: random backpressure, compare against oldest prediction
  always @(negedge clk) begin
    if (!stall_enable) out_tready <= 1'b1;
    else if ($urandom_range(0, 49) == 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    retire_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = retire_t'(out_tdata[201:0]);
      if (pending_retires.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = pending_retires.pop_front();
        if (got.next_pc != want.next_pc) begin
          $error("next_pc exp %h got %h", want.next_pc, got.next_pc); errors++; end
        if (got.halted != want.halted) begin
          $error("halted exp %0d got %0d", want.halted, got.halted); errors++; end
        if (got.reg_written != want.reg_written) begin
          $error("reg_written exp %0d got %0d", want.reg_written, got.reg_written); errors++; end
        if (got.reg_index != want.reg_index) begin
          $error("reg_index exp %0d got %0d", want.reg_index, got.reg_index); errors++; end
        if (got.reg_value != want.reg_value) begin
          $error("reg_value exp %h got %h", want.reg_value, got.reg_value); errors++; end
        if (got.hi_value != want.hi_value) begin
          $error("hi_value exp %h got %h", want.hi_value, got.hi_value); errors++; end
        if (got.lo_value != want.lo_value) begin
          $error("lo_value exp %h got %h", want.lo_value, got.lo_value); errors++; end
        if (got.overflow != want.overflow) begin
          $error("overflow exp %0d got %0d", want.overflow, got.overflow); errors++; end
        if (got.divide_by_zero != want.divide_by_zero) begin
          $error("divide_by_zero exp %0d got %0d", want.divide_by_zero,
                 got.divide_by_zero); errors++; end
        if (got.mem_written != want.mem_written) begin
          $error("mem_written exp %0d got %0d", want.mem_written, got.mem_written); errors++; end
        if (got.mem_address != want.mem_address) begin
          $error("mem_address exp %h got %h", want.mem_address, got.mem_address); errors++; end
        if (got.mem_value != want.mem_value) begin
          $error("mem_value exp %h got %h", want.mem_value, got.mem_value); errors++; end
      end
    end
  end

  task automatic test_alu_extremes();
    set_reg(5'd8, 32'h7FFF_FFFF);
    set_reg(5'd9, 32'h8000_0000);
    set_reg(5'd10, 32'hFFFF_FFFF);
    exec(r_type(5'd8, 5'd8, 5'd11, 5'd0, FN_ADD));     // positive overflow
    exec(r_type(5'd9, 5'd8, 5'd12, 5'd0, FN_SUB));     // negative overflow
    exec(i_type(OP_ADDI, 5'd8, 5'd13, 16'h0001));      // addi overflow
    exec(i_type(OP_SLTIU, 5'd10, 5'd14, 16'hFFFF));    // sign-extended unsigned compare
    exec(r_type(5'd0, 5'd9, 5'd0, 5'd31, FN_SRA));     // shift into $0 skipped
    exec(r_type(5'd0, 5'd9, 5'd15, 5'd31, FN_SRA));
    exec(r_type(5'd10, 5'd9, 5'd0, 5'd0, FN_ADDU));    // write to $0 dropped
  endtask

  task automatic test_muldiv();
    exec(r_type(5'd9, 5'd10, 5'd0, 5'd0, FN_DIV));     // most negative / -1
    exec(r_type(5'd8, 5'd0, 5'd0, 5'd0, FN_DIV));      // divide by zero
    exec(r_type(5'd8, 5'd0, 5'd0, 5'd0, FN_DIVU));
    exec(r_type(5'd10, 5'd10, 5'd0, 5'd0, FN_MULTU));
    exec(r_type(5'd0, 5'd0, 5'd16, 5'd0, FN_MFHI));
  endtask

  task automatic test_memory();
    send_beat(CMD_PRELOAD, '0, 12'hFFE, 32'h8081_F2F3); // wraps past the top
    exec(i_type(OP_LW, 5'd0, 5'd17, 16'h0FFE));
    exec(i_type(OP_LB, 5'd0, 5'd18, 16'h0FFF));
    exec(i_type(OP_LH, 5'd0, 5'd19, 16'h0000));
    exec(i_type(OP_SH, 5'd10, 5'd9, 16'hFFFF));
  endtask

  task automatic test_halt();
    exec(i_type(OP_ORI, 5'd0, REG_V0, 16'h0005));
    exec(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));  // not exit, nop
    exec(i_type(OP_ORI, 5'd0, REG_V0, 16'h000A));
    exec(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    exec(i_type(OP_ADDIU, 5'd0, 5'd5, 16'h1234));      // ignored once halted
    send_beat(CMD_PRELOAD, '0, 12'h010, 32'hDEAD_BEEF);
  endtask

  function automatic logic [31:0] random_instr();
    logic [5:0] ops [24] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM,
      OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
      OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_SB, OP_SW};
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: ;                                       // raw word, may be unknown code
      1: w[31:26] = $urandom_range(0, 1) ? OP_LBU : OP_LHU;
      2: w[31:26] = OP_SH;
      default: w[31:26] = ops[$urandom_range(0, 23)];
    endcase
    // syscall with $v0 = 10 would end the run early
    if (w[31:26] == OP_SPECIAL && w[5:0] == FN_SYSCALL) w[5:0] = FN_ADDU;
    if (w[31:26] == OP_SPECIAL && (w[5:0] == FN_DIV || w[5:0] == FN_DIVU) &&
        $urandom_range(0, 2) != 0) w[5:0] = FN_MULT;
    return w;
  endfunction

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_beat(CMD_PRELOAD, $urandom(), 12'($urandom_range(0, 4095)), $urandom());
      else if ($urandom_range(0, 7) == 0)
        set_reg(5'($urandom_range(1, 31)), $urandom());
      else
        exec(random_instr());
    end
  endtask

  initial begin
    model_reset();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_alu_extremes();
    test_muldiv();
    test_memory();
    test_random(735);
    test_halt();
    write_start_pc(32'hFFFF_FFFC);               // reloading PC does not clear halt
    stall_enable = 1'b0;
    drain();
    stall_enable = 1'b1;
    // restart a fresh run needs reset; halt is sticky, so only preloads remain
    send_beat(CMD_PRELOAD, '0, 12'h000, 32'h0000_0001);
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[mips32_integer_execute.f]
hw/rtl/mie_pkg.sv
hw/rtl/mie_ctrl.sv
hw/rtl/mie_datapath.sv
hw/rtl/mips32_integer_execute.sv
tb/mips32_integer_execute_test.sv
